### design/eevd_pkg.sv
// eevd_pkg: shared types and constants of the energy envelope voice detector
// used by eevd_back and the top level
`timescale 1ns / 1ps

package eevd_pkg;

  // configuration register indexes (word address)
  localparam logic [2:0] REG_ENVELOPE_COEF  = 3'd0;
  localparam logic [2:0] REG_ATTACK_COEF    = 3'd1;
  localparam logic [2:0] REG_DECAY_COEF     = 3'd2;
  localparam logic [2:0] REG_INIT_FRAMES    = 3'd3;
  localparam logic [2:0] REG_HOLD_FRAMES    = 3'd4;
  localparam logic [2:0] REG_RATIO          = 3'd5;
  localparam logic [2:0] REG_MIN_PEAK_LEVEL = 3'd6;
  localparam logic [2:0] REG_MIN_SPREAD     = 3'd7;

  // phrase state codes
  localparam logic [1:0] PHRASE_SILENT  = 2'd0;
  localparam logic [1:0] PHRASE_STARTED = 2'd1;
  localparam logic [1:0] PHRASE_ENDED   = 2'd2;

  // fixed constants
  localparam logic [17:0]        DB_PER_LOG2     = 18'd197284;
  localparam logic signed [15:0] ENV_RESET       = -16'sd2560;
  localparam logic signed [16:0] NEAR_MAX_MARGIN = 17'sd128;
  localparam logic [7:0]         START_RUN       = 8'd10;
  localparam logic [7:0]         END_RUN         = 8'd15;
  localparam logic [7:0]         RUN_MAX         = 8'd255;
  localparam logic [15:0]        WARM_MAX        = 16'hFFFF;

  // configuration register set
  typedef struct packed {
    logic [15:0]        envelope_coef;
    logic [15:0]        attack_coef;
    logic [15:0]        decay_coef;
    logic [15:0]        init_frames;
    logic [15:0]        hold_frames;
    logic [15:0]        ratio;
    logic signed [15:0] min_peak_level;
    logic [14:0]        min_spread;
  } cfg_t;

endpackage

### design/energy_envelope_voice_detector.sv
// energy_envelope_voice_detector: top level with configuration registers
// instantiates eevd_front, eevd_queue and eevd_back; uses eevd_pkg
//
// Usage: samples enter on the in channel (in_valid_i, in_stall_o, sample_i,
// frame_end_i); a sample is taken at an edge with valid high and stall low.
// Every sample flagged frame_end gives one request on the out channel
// (out_valid_o, out_stall_i, voice_o, phrase_state_o, frame_level_o); other
// samples give none. Samples are taken one per cycle while the queue is not
// full. A frame peak goes into a two-entry queue; the back sequencer takes
// each frame through its steps (pop, normalize steps, 16 log2 squaring steps,
// dB, envelope, two tracker steps, voice, output load) and registers the
// result at output load. in_stall_o rises only when the queue is full, i.e.
// when frame ends come faster than the sequencer finishes them. A stalled
// result is held in the output register; the sequencer waits behind it and
// the queue absorbs up to two further frames. Reset puts the peak at its
// floor, the envelope at -10 dB, trackers and counters at zero and registers
// at their defaults. Registers sit on an APB port at byte address 4*index;
// the user must write them only while the block is idle, as the block itself
// does not enforce this.
`timescale 1ns / 1ps

module energy_envelope_voice_detector #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          voice_o,
  output logic [1:0]                    phrase_state_o,
  output logic signed [15:0]            frame_level_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int PEAK_W = 2 * SAMPLE_BITS - 1;

  eevd_pkg::cfg_t    cfg_q;
  logic              wr_en;
  logic              q_full, q_valid, push, pop;
  logic [PEAK_W-1:0] push_data, q_data;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.envelope_coef  <= 16'd655;
      cfg_q.attack_coef    <= 16'd655;
      cfg_q.decay_coef     <= 16'd66;
      cfg_q.init_frames    <= 16'd31;
      cfg_q.hold_frames    <= 16'd62;
      cfg_q.ratio          <= 16'd2048;
      cfg_q.min_peak_level <= -16'sd15360;
      cfg_q.min_spread     <= 15'd1536;
    end else if (wr_en) begin
      case (paddr[4:2])
        eevd_pkg::REG_ENVELOPE_COEF:  cfg_q.envelope_coef  <= pwdata[15:0];
        eevd_pkg::REG_ATTACK_COEF:    cfg_q.attack_coef    <= pwdata[15:0];
        eevd_pkg::REG_DECAY_COEF:     cfg_q.decay_coef     <= pwdata[15:0];
        eevd_pkg::REG_INIT_FRAMES:    cfg_q.init_frames    <= pwdata[15:0];
        eevd_pkg::REG_HOLD_FRAMES:    cfg_q.hold_frames    <= pwdata[15:0];
        eevd_pkg::REG_RATIO:          cfg_q.ratio          <= pwdata[15:0];
        eevd_pkg::REG_MIN_PEAK_LEVEL: cfg_q.min_peak_level <= pwdata[15:0];
        eevd_pkg::REG_MIN_SPREAD:     cfg_q.min_spread     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[4:2])
      eevd_pkg::REG_ENVELOPE_COEF:  prdata = {16'b0, cfg_q.envelope_coef};
      eevd_pkg::REG_ATTACK_COEF:    prdata = {16'b0, cfg_q.attack_coef};
      eevd_pkg::REG_DECAY_COEF:     prdata = {16'b0, cfg_q.decay_coef};
      eevd_pkg::REG_INIT_FRAMES:    prdata = {16'b0, cfg_q.init_frames};
      eevd_pkg::REG_HOLD_FRAMES:    prdata = {16'b0, cfg_q.hold_frames};
      eevd_pkg::REG_RATIO:          prdata = {16'b0, cfg_q.ratio};
      eevd_pkg::REG_MIN_PEAK_LEVEL: prdata = {16'b0, cfg_q.min_peak_level};
      eevd_pkg::REG_MIN_SPREAD:     prdata = {17'b0, cfg_q.min_spread};
      default:                      prdata = '0;
    endcase
  end

  // sample front end
  eevd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PEAK_W      (PEAK_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .frame_end_i (frame_end_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // frame peak queue
  eevd_queue #(
    .WIDTH (PEAK_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // per-frame sequencer
  eevd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PEAK_W      (PEAK_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .voice_o        (voice_o),
    .phrase_state_o (phrase_state_o),
    .frame_level_o  (frame_level_o)
  );

endmodule

### design/eevd_front.sv
// eevd_front: accepts samples and tracks the squared frame peak
// pushes the peak of each finished frame into eevd_queue
`timescale 1ns / 1ps

module eevd_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int PEAK_W      = 2 * SAMPLE_BITS - 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          frame_end_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output logic [PEAK_W-1:0]             push_data_o
);

  logic [PEAK_W-1:0]        peak_q, peak_d;
  logic signed [2*SAMPLE_BITS-1:0] sq_full;
  logic [PEAK_W-1:0]        sq;
  logic [PEAK_W-1:0]        new_peak;
  logic                     accept;

  // square of the sample and running maximum
  assign sq_full  = sample_i * sample_i;
  assign sq       = sq_full[PEAK_W-1:0];
  assign new_peak = (sq > peak_q) ? sq : peak_q;

  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i & ~q_full_i;
  assign push_o      = accept & frame_end_i;
  assign push_data_o = new_peak;

  // peak restarts from the floor after each frame end
  always_comb begin
    peak_d = peak_q;
    if (accept) begin
      peak_d = frame_end_i ? PEAK_W'(1) : new_peak;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= PEAK_W'(1);
    end else begin
      peak_q <= peak_d;
    end
  end

endmodule

### design/eevd_queue.sv
// eevd_queue: two-entry queue of frame peaks between front and back
// depends on nothing but its parameters
`timescale 1ns / 1ps

module eevd_queue #(
  parameter int WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i) else $error("pop from empty queue");
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

endmodule

### design/eevd_back.sv
// eevd_back: per-frame sequencer: log level, envelope, trackers, voice, phrase
// pops frame peaks from eevd_queue and holds the result register; uses eevd_pkg
`timescale 1ns / 1ps

module eevd_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int PEAK_W      = 2 * SAMPLE_BITS - 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eevd_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  logic [PEAK_W-1:0]   q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                voice_o,
  output logic [1:0]          phrase_state_o,
  output logic signed [15:0]  frame_level_o
);

  localparam int EXP_W  = $clog2(PEAK_W);
  localparam int NSTEPS = $clog2(PEAK_W);
  localparam int DIFF_W = EXP_W + 17;
  localparam int PROD_W = DIFF_W + 18;
  localparam logic [EXP_W-1:0] FULL_E = EXP_W'(PEAK_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_MANT, ST_LOG, ST_DB, ST_ENV,
    ST_MAXT, ST_MINT, ST_VOICE, ST_OUT
  } state_e;

  state_e             state_q;
  logic [PEAK_W-1:0]  norm_q;
  logic [EXP_W-1:0]   exp_q;
  logic [3:0]         cnt_q;
  logic [31:0]        m_q;
  logic [15:0]        frac_q;
  logic signed [15:0] level_q, env_q, max_q, min_q;
  logic [15:0]        warm_q, near_q;
  logic [7:0]         act_q, sil_q;
  logic [1:0]         phrase_q;
  logic               voice_q;
  logic               out_valid_q;
  logic               res_voice_q;
  logic [1:0]         res_phrase_q;
  logic signed [15:0] res_level_q;

  // one-pole smoothing step, one multiply
  function automatic logic signed [15:0] smooth(input logic signed [15:0] y,
                                                input logic signed [15:0] x,
                                                input logic [15:0] w);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [17:0] stp;
    logic signed [17:0] sum;
    d   = {x[15], x} - {y[15], y};
    p   = d * $signed({1'b0, w});
    p   = p + 34'sd32768;
    stp = 18'(p >>> 16);
    sum = {{2{y[15]}}, y} + stp;
    return sum[15:0];
  endfunction

  // normalization step: shift by a power of two if the top bits are zero
  logic [EXP_W-1:0]  shift_amt;
  logic              top_zero;
  always_comb begin
    shift_amt = EXP_W'(1) << cnt_q;
    top_zero  = 1'b1;
    for (int i = 0; i < PEAK_W; i++) begin
      if (i >= PEAK_W - int'(shift_amt)) begin
        top_zero = top_zero & ~norm_q[i];
      end
    end
  end

  // mantissa taken from the top of the normalized peak
  logic [PEAK_W+31:0] norm_ext;
  assign norm_ext = {norm_q, 32'b0};

  // log2 fraction squaring step
  logic [63:0] m_sq;
  logic [32:0] m_sh;
  assign m_sq = m_q * m_q;
  assign m_sh = m_sq[63:31];

  // distance below full scale in log2 units, then dB magnitude
  logic signed [DIFF_W-1:0] diff_s;
  logic [DIFF_W-1:0]        diff;
  logic [PROD_W-1:0]        db_prod, db_round, mag_full;
  logic [16:0]              mag;
  assign diff_s   = $signed({1'b0, FULL_E - exp_q, 16'b0}) - $signed({{(EXP_W+1){1'b0}}, frac_q});
  assign diff     = diff_s[DIFF_W-1] ? '0 : diff_s;
  assign db_prod  = PROD_W'(diff) * PROD_W'(eevd_pkg::DB_PER_LOG2);
  assign db_round = db_prod + PROD_W'(24'h800000);
  assign mag_full = db_round >> 24;
  assign mag      = (mag_full > PROD_W'(32768)) ? 17'd32768 : mag_full[16:0];

  // voice decision terms
  logic signed [16:0] spread, dyn, near_gap;
  logic signed [34:0] lhs, rhs;
  logic               voice_raw, near_hit, voice_fin;
  logic [7:0]         act_n, sil_n;
  logic [1:0]         phrase_n;
  always_comb begin
    spread    = {max_q[15], max_q} - {min_q[15], min_q};
    dyn       = {env_q[15], env_q} - {min_q[15], min_q};
    near_gap  = {max_q[15], max_q} - {env_q[15], env_q};
    lhs       = {{6{dyn[16]}}, dyn, 12'b0};
    rhs       = spread * $signed({1'b0, cfg_i.ratio});
    voice_raw = lhs > rhs;
    if (max_q < cfg_i.min_peak_level) begin
      voice_raw = 1'b0;
    end
    if (spread < $signed({2'b0, cfg_i.min_spread})) begin
      voice_raw = 1'b0;
    end
    near_hit  = near_gap < eevd_pkg::NEAR_MAX_MARGIN;
    voice_fin = voice_raw;
    if (near_hit && !(near_q < cfg_i.hold_frames)) begin
      voice_fin = 1'b0;
    end
    if (voice_fin) begin
      act_n = (act_q < eevd_pkg::RUN_MAX) ? act_q + 8'd1 : act_q;
      sil_n = 8'd0;
    end else begin
      sil_n = (sil_q < eevd_pkg::RUN_MAX) ? sil_q + 8'd1 : sil_q;
      act_n = 8'd0;
    end
    phrase_n = phrase_q;
    if (act_n > eevd_pkg::START_RUN) begin
      phrase_n = eevd_pkg::PHRASE_STARTED;
    end
    if (phrase_n == eevd_pkg::PHRASE_STARTED && sil_n > eevd_pkg::END_RUN) begin
      phrase_n = eevd_pkg::PHRASE_ENDED;
    end
  end

  assign pop_o          = (state_q == ST_IDLE) & q_valid_i;
  assign out_valid_o    = out_valid_q;
  assign voice_o        = res_voice_q;
  assign phrase_state_o = res_phrase_q;
  assign frame_level_o  = res_level_q;

  // sequencer, frame state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      norm_q      <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      m_q         <= '0;
      frac_q      <= '0;
      level_q     <= '0;
      env_q       <= eevd_pkg::ENV_RESET;
      max_q       <= '0;
      min_q       <= '0;
      warm_q      <= '0;
      near_q      <= '0;
      act_q       <= '0;
      sil_q       <= '0;
      phrase_q    <= eevd_pkg::PHRASE_SILENT;
      voice_q     <= 1'b0;
      out_valid_q <= 1'b0;
      res_voice_q  <= 1'b0;
      res_phrase_q <= eevd_pkg::PHRASE_SILENT;
      res_level_q  <= '0;
    end else begin
      // result taken and nothing new to load
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            norm_q  <= q_data_i;
            exp_q   <= FULL_E;
            cnt_q   <= 4'(NSTEPS - 1);
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (top_zero) begin
            norm_q <= norm_q << shift_amt;
            exp_q  <= exp_q - shift_amt;
          end
          if (cnt_q == 4'd0) begin
            state_q <= ST_MANT;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        ST_MANT: begin
          m_q     <= norm_ext[PEAK_W+31 -: 32];
          frac_q  <= '0;
          cnt_q   <= 4'd0;
          state_q <= ST_LOG;
        end
        ST_LOG: begin
          m_q    <= m_sh[32] ? m_sh[32:1] : m_sh[31:0];
          frac_q <= {frac_q[14:0], m_sh[32]};
          cnt_q  <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= ST_DB;
          end
        end
        ST_DB: begin
          level_q <= 16'(-$signed(mag));
          state_q <= ST_ENV;
        end
        ST_ENV: begin
          env_q   <= smooth(env_q, level_q, cfg_i.envelope_coef);
          state_q <= ST_MAXT;
        end
        ST_MAXT: begin
          if (warm_q > cfg_i.init_frames) begin
            max_q <= (env_q > max_q) ? env_q : smooth(max_q, env_q, cfg_i.decay_coef);
          end else begin
            max_q <= env_q;
          end
          state_q <= ST_MINT;
        end
        ST_MINT: begin
          if (warm_q > cfg_i.init_frames) begin
            min_q <= (env_q > min_q) ? smooth(min_q, env_q, cfg_i.attack_coef) : env_q;
          end else begin
            min_q <= env_q;
            if (warm_q < eevd_pkg::WARM_MAX) begin
              warm_q <= warm_q + 16'd1;
            end
          end
          state_q <= ST_VOICE;
        end
        ST_VOICE: begin
          if (near_hit) begin
            if (near_q < cfg_i.hold_frames) begin
              near_q <= near_q + 16'd1;
            end
          end else begin
            near_q <= '0;
          end
          act_q    <= act_n;
          sil_q    <= sil_n;
          phrase_q <= phrase_n;
          voice_q  <= voice_fin;
          state_q  <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            res_voice_q  <= voice_q;
            res_phrase_q <= phrase_q;
            res_level_q  <= env_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_pop_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_NORM) else $error("pop did not start a frame");
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(res_level_q)))
    else $error("stalled result changed");
  a_phrase_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phrase_q != 2'd3) else $error("bad phrase code");

endmodule

### test/tb.sv
// tb: self-checking testbench of energy_envelope_voice_detector
// drives samples and register writes, predicts each frame result; uses eevd_pkg
`timescale 1ns / 1ps

class frame_scoreboard;
  // register copy
  int unsigned env_w, atk_w, dec_w, init_n, hold_n, ratio_q;
  int          peak_floor_db;
  int unsigned spread_min;
  // detector state
  longint unsigned peak;
  int          env, hi_trk, lo_trk;
  int unsigned warm, near_cnt, act_run, sil_run;
  logic [1:0]  phrase;
  // pending frame results {voice, phrase, level}
  logic [18:0] pending[$];
  int          mismatches;
  int          frames_checked;

  function new();
    env_w = 655; atk_w = 655; dec_w = 66; init_n = 31; hold_n = 62;
    ratio_q = 2048; peak_floor_db = -15360; spread_min = 1536;
    peak = 1; env = -2560; hi_trk = 0; lo_trk = 0;
    warm = 0; near_cnt = 0; act_run = 0; sil_run = 0;
    phrase = eevd_pkg::PHRASE_SILENT;
    mismatches = 0; frames_checked = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      eevd_pkg::REG_ENVELOPE_COEF:  env_w = v[15:0];
      eevd_pkg::REG_ATTACK_COEF:    atk_w = v[15:0];
      eevd_pkg::REG_DECAY_COEF:     dec_w = v[15:0];
      eevd_pkg::REG_INIT_FRAMES:    init_n = v[15:0];
      eevd_pkg::REG_HOLD_FRAMES:    hold_n = v[15:0];
      eevd_pkg::REG_RATIO:          ratio_q = v[15:0];
      eevd_pkg::REG_MIN_PEAK_LEVEL: peak_floor_db = $signed(v[15:0]);
      default:                      spread_min = v[14:0];
    endcase
  endfunction

  // one-pole step, rounding then flooring the q16 product
  function int one_pole(int y, int x, int unsigned w);
    longint p;
    p = longint'(x - y) * longint'(w) + 32768;
    return y + int'(p >>> 16);
  endfunction

  // truncated log2 in q16 by repeated squaring
  function longint unsigned log2_fix(longint unsigned x);
    int e;
    longint unsigned m, frac;
    frac = 0;
    if (x == 0) x = 1;
    e = 63;
    while (x[e] == 1'b0) e--;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function int level_db(longint unsigned p);
    longint unsigned full, lg, diff, mag;
    full = 64'd30 << 16;
    lg = log2_fix(p);
    diff = (lg >= full) ? 0 : full - lg;
    mag = (diff * 197284 + (64'd1 << 23)) >> 24;
    if (mag > 32768) mag = 32768;
    return -int'(mag);
  endfunction

  // note an accepted sample
  function void note_sample(logic signed [15:0] s, logic fe);
    longint unsigned sq;
    longint sp, dyn;
    bit v;
    sq = longint'(s) * longint'(s);
    if (sq > peak) peak = sq;
    if (!fe) return;
    env = one_pole(env, level_db(peak), env_w);
    peak = 1;
    if (warm > init_n) begin
      hi_trk = (env > hi_trk) ? env : one_pole(hi_trk, env, dec_w);
      lo_trk = (env > lo_trk) ? one_pole(lo_trk, env, atk_w) : env;
    end else begin
      hi_trk = env; lo_trk = env;
      if (warm < 65535) warm++;
    end
    sp = hi_trk - lo_trk;
    dyn = env - lo_trk;
    v = (dyn * 4096 > longint'(ratio_q) * sp);
    if (hi_trk < peak_floor_db) v = 0;
    if (sp < longint'(spread_min)) v = 0;
    if (sp - dyn < 128) begin
      if (near_cnt < hold_n) near_cnt++;
      else v = 0;
    end else near_cnt = 0;
    if (v) begin
      if (act_run < 255) act_run++;
      sil_run = 0;
    end else begin
      if (sil_run < 255) sil_run++;
      act_run = 0;
    end
    if (act_run > 10) phrase = eevd_pkg::PHRASE_STARTED;
    if (phrase == eevd_pkg::PHRASE_STARTED && sil_run > 15) phrase = eevd_pkg::PHRASE_ENDED;
    pending.push_back({v, phrase, env[15:0]});
  endfunction

  // compare one result request with the oldest expectation
  function void check_result(logic v, logic [1:0] ph, logic [15:0] lvl);
    logic [18:0] e;
    frames_checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result voice=%0d phrase=%0d level=%0d",
                                     v, ph, $signed(lvl));
      return;
    end
    e = pending.pop_front();
    if (e != {v, ph, lvl}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("frame %0d: exp voice=%0d phrase=%0d level=%0d, got %0d %0d %0d",
                 frames_checked, e[18], e[17:16], $signed(e[15:0]), v, ph, $signed(lvl));
    end
  endfunction
endclass

module tb;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic signed [15:0] sample_i = 0;
  logic               frame_end_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic               voice_o;
  logic [1:0]         phrase_state_o;
  logic signed [15:0] frame_level_o;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [4:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  frame_scoreboard sb = new();
  int  cycles = 0;
  int  hold_off = 0;     // receiver long stall, cycles left
  bit  rx_random = 1;
  int  frames_sent = 0;

  energy_envelope_voice_detector DUT (.*);

  always #1 clk_i = ~clk_i;

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: checks and random stalls
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(voice_o, phrase_state_o, frame_level_o);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= 0;
      if (rx_random && out_valid_o && !out_stall_i && $urandom_range(3) == 0)
        stall_left <= $urandom_range(17);
    end
  end

  // send one sample, waiting for acceptance; valid stays up for a follow-on
  task automatic send_sample(logic signed [15:0] s, logic fe, int gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1; sample_i <= s; frame_end_i <= fe;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s, fe);
    if (fe) frames_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // setup and access phase; the bus is released by set_all
  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.write_reg(idx, {16'h0, v});
  endtask

  // a frame of n random samples with the given amplitude limit
  task automatic send_frame(int n, int amp, bit gaps);
    for (int i = 0; i < n; i++)
      send_sample(16'($signed($urandom_range(2 * amp)) - amp), i == n - 1,
                  gaps ? $urandom_range(17) * ($urandom_range(2) == 0) : 0);
  endtask

  task automatic set_all(logic [15:0] a, b, c, d, e, f, g, h);
    write_reg(eevd_pkg::REG_ENVELOPE_COEF, a);  write_reg(eevd_pkg::REG_ATTACK_COEF, b);
    write_reg(eevd_pkg::REG_DECAY_COEF, c);     write_reg(eevd_pkg::REG_INIT_FRAMES, d);
    write_reg(eevd_pkg::REG_HOLD_FRAMES, e);    write_reg(eevd_pkg::REG_RATIO, f);
    write_reg(eevd_pkg::REG_MIN_PEAK_LEVEL, g); write_reg(eevd_pkg::REG_MIN_SPREAD, h);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  int amp;
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes of the sample, silence, lone frame-end samples
    send_sample(16'sh7FFF, 0, 0);
    send_sample(-16'sh8000, 1, 0);
    send_sample(16'sh0000, 1, 0);
    send_sample(16'sh0001, 1, 0);
    send_sample(-16'sh0001, 0, 3);
    send_sample(16'sh5555, 0, 0);
    send_sample(-16'sh2AAB, 1, 0);
    for (int i = 0; i < 12; i++) send_sample(i[0] ? 16'sh7FFF : 16'sh0000, 1, 0);
    drain();

    // fast settings: short warm-up, low hold, quick filters
    set_all(16'hFFFF, 16'h4000, 16'h2000, 16'd2, 16'd3, 16'd1024, -16'sd32768, 16'd0);
    for (int f = 0; f < 60; f++) begin
      amp = (f % 20 < 10) ? 32767 : $urandom_range(40);
      send_frame($urandom_range(1, 4), amp, 1);
    end
    drain();

    // receiver holds off while frames pile up and stall the input
    hold_off = 300;
    for (int f = 0; f < 10; f++) send_frame(1, 32767, 0);
    drain();

    // zero weights hold the filters; warm-up that never ends
    set_all(16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'h7FFF);
    for (int f = 0; f < 20; f++) send_frame($urandom_range(1, 3), 32767, 1);
    drain();

    // random phases with random settings, bursts of loud and quiet frames
    for (int ph = 0; ph < 4; ph++) begin
      set_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 16'($urandom_range(8)),
              16'($urandom_range(20)), 16'($urandom_range(8192)),
              16'($urandom_range(65535)), 16'($urandom_range(32767)));
      for (int f = 0; f < 40; f++) begin
        amp = ($urandom_range(3) == 0) ? $urandom_range(32767)
              : ((f / 12) % 2 ? 32767 : $urandom_range(8));
        send_frame($urandom_range(1, 6), amp, 1);
      end
      drain();
    end

    // defaults back
    set_all(16'd655, 16'd655, 16'd66, 16'd31, 16'd62, 16'd2048, -16'sd15360, 16'd1536);
    for (int f = 0; f < 50; f++) send_frame($urandom_range(1, 5), (f / 15) % 2 ? 32767 : 3, 1);
    drain();

    $display("covered %0d frames over several register settings, stalls and hold-offs",
             frames_sent);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### sim.f
design/eevd_pkg.sv
design/eevd_front.sv
design/eevd_queue.sv
design/eevd_back.sv
design/energy_envelope_voice_detector.sv
test/tb.sv
